// File: rtl/core/bcache_pkg.sv
package bcache_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 64;
    localparam int CNT_W      = 32;
    localparam int COUNT_W    = 5;
    localparam int CAP_W      = 5;
    localparam int OP_W       = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
    localparam logic [COUNT_W-1:0] DEPTH_CNT  = COUNT_W'(DEPTH);

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0
    } t_reg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic capture;
        logic apply;
        t_op  op;
        logic hit;
        logic evict;
    } t_cell_cmd;

endpackage

// File: rtl/core/bcache_if.sv
interface bcache_req_if;
    logic                          valid;
    logic                          ready;
    logic [bcache_pkg::OP_W-1:0]    op;
    logic [bcache_pkg::KEY_W-1:0]   key;
    logic [bcache_pkg::VALUE_W-1:0] value_in;

    modport source (output valid, op, key, value_in, input ready);
    modport sink   (input valid, op, key, value_in, output ready);
endinterface

interface bcache_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [bcache_pkg::VALUE_W-1:0] read_value;
    logic [bcache_pkg::COUNT_W-1:0] entry_count;
    logic [bcache_pkg::CNT_W-1:0]   hit_total;
    logic [bcache_pkg::CNT_W-1:0]   miss_total;

    modport source (output valid, found, read_value, entry_count, hit_total, miss_total,
                    input ready);
    modport sink   (input valid, found, read_value, entry_count, hit_total, miss_total,
                    output ready);
endinterface

// File: rtl/core/bounded_cache_min_key_evict.sv
// channel  dir  handshake      word
// i_req    in   valid/ready    op, key, value_in
// o_rsp    out  valid/ready    found, read_value, entry_count, hit_total, miss_total
// apb      in   psel/penable   capacity at paddr 0
//
// The row compares every slot against the key on accept, then shifts and
// writes the sorted row in S_APPLY; i_req is not ready again until S_IDLE.
// Slots stay sorted by key, so eviction takes the head of the row.
// i_rst_n is synchronous: it empties the row, zeroes the counters and sets
// capacity to 16. A stalled o_rsp holds the finished word and blocks the
// write-back of the next item until the output register frees up.
module bounded_cache_min_key_evict (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    bcache_req_if.sink                           i_req,
    bcache_rsp_if.source                         o_rsp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bcache_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bcache_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bcache_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state                             r_state, n_state;
    bcache_pkg::t_op                    r_op;
    logic [bcache_pkg::KEY_W-1:0]       r_key;
    logic [bcache_pkg::VALUE_W-1:0]     r_value;
    logic [bcache_pkg::CAP_W-1:0]       r_cap;
    logic [bcache_pkg::COUNT_W-1:0]     r_held, n_held;
    logic [bcache_pkg::CNT_W-1:0]       r_hit, n_hit;
    logic [bcache_pkg::CNT_W-1:0]       r_miss, n_miss;
    logic                               r_out_valid;
    logic                               r_found;
    logic [bcache_pkg::VALUE_W-1:0]     r_read_value;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_apply;
    logic                               w_hit;
    logic                               w_found;
    logic [bcache_pkg::VALUE_W-1:0]     w_row_value;
    logic [bcache_pkg::DEPTH-1:0]       w_valid;
    logic [bcache_pkg::COUNT_W-1:0]     w_eff_cap;
    logic                               w_cfg_wr;
    bcache_pkg::t_reg_idx               w_reg_idx;
    bcache_pkg::t_cell_cmd              w_cmd;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_apply     = (r_state == S_APPLY) && w_out_free;

    assign w_eff_cap = (r_cap == '0) ? bcache_pkg::COUNT_W'(1) :
                       (bcache_pkg::COUNT_W'(r_cap) > bcache_pkg::DEPTH_CNT) ?
                       bcache_pkg::DEPTH_CNT : bcache_pkg::COUNT_W'(r_cap);

    assign w_cmd = '{capture: w_accept,
                     apply:   w_apply,
                     op:      r_op,
                     hit:     w_hit,
                     evict:   (r_held >= w_eff_cap)};

    bcache_row u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmp_key    (i_req.key),
        .i_new_key    (r_key),
        .i_new_value  (r_value),
        .o_hit        (w_hit),
        .o_read_value (w_row_value),
        .o_valid      (w_valid)
    );

    assign w_found = (r_op == bcache_pkg::OP_LOOKUP) && w_hit;

    always_comb begin
        n_held = r_held;
        n_hit  = r_hit;
        n_miss = r_miss;
        case (r_op)
            bcache_pkg::OP_LOOKUP: begin
                if (w_hit) begin
                    n_hit = (r_hit == '1) ? r_hit : r_hit + 1'b1;
                end else begin
                    n_miss = (r_miss == '1) ? r_miss : r_miss + 1'b1;
                end
            end
            bcache_pkg::OP_STORE: begin
                if (!w_hit && !w_cmd.evict) begin
                    n_held = r_held + 1'b1;
                end
            end
            bcache_pkg::OP_REMOVE: begin
                if (w_hit) begin
                    n_held = r_held - 1'b1;
                end
            end
            bcache_pkg::OP_CLEAR: begin
                n_held = '0;
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_hit       <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= bcache_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_held      <= n_held;
                r_hit       <= n_hit;
                r_miss      <= n_miss;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr && (w_reg_idx == bcache_pkg::REG_CAPACITY)) begin
                r_cap <= pwdata[bcache_pkg::CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= bcache_pkg::t_op'(i_req.op);
            r_key   <= i_req.key;
            r_value <= i_req.value_in;
        end
        if (w_apply) begin
            r_found      <= w_found;
            r_read_value <= w_found ? w_row_value : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.read_value  = r_read_value;
    assign o_rsp.entry_count = r_held;
    assign o_rsp.hit_total   = r_hit;
    assign o_rsp.miss_total  = r_miss;

    assign pready    = 1'b1;
    assign w_reg_idx = bcache_pkg::t_reg_idx'(paddr[2]);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign prdata    = (w_reg_idx == bcache_pkg::REG_CAPACITY) ?
                       {{(bcache_pkg::APB_DATA_W - bcache_pkg::CAP_W){1'b0}}, r_cap} : '0;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= bcache_pkg::DEPTH_CNT)
        else $error("entry count above depth");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_held))
        else $error("entry count differs from occupied slots");

    a_row_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("occupied slots not packed at row head");

    a_hit_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) || (r_hit >= $past(r_hit)))
        else $error("hit counter went down");

endmodule

// File: rtl/core/bcache_cell.sv
module bcache_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bcache_pkg::t_cell_cmd          i_cmd,
    input  logic                           i_first,
    input  logic [bcache_pkg::KEY_W-1:0]   i_cmp_key,
    input  bcache_pkg::t_slot              i_new,
    input  bcache_pkg::t_slot              i_left,
    input  logic                           i_left_lt,
    input  bcache_pkg::t_slot              i_right,
    input  logic                           i_right_lt,
    output bcache_pkg::t_slot              o_slot,
    output logic                           o_lt,
    output logic                           o_eq
);

    logic                             r_valid;
    logic [bcache_pkg::KEY_W-1:0]     r_key;
    logic [bcache_pkg::VALUE_W-1:0]   r_value;
    logic                             r_lt;
    logic                             r_eq;
    bcache_pkg::t_slot                w_cur;
    bcache_pkg::t_slot                n_slot;

    assign w_cur = '{valid: r_valid, key: r_key, value: r_value};

    always_comb begin
        n_slot = w_cur;
        case (i_cmd.op)
            bcache_pkg::OP_LOOKUP: begin
                n_slot = w_cur;
            end
            bcache_pkg::OP_STORE: begin
                if (i_cmd.hit) begin
                    if (r_eq) begin
                        n_slot.value = i_new.value;
                    end
                end else if (!i_cmd.evict) begin
                    // open a gap at the insert point, push larger keys right
                    if (!r_lt) begin
                        n_slot = i_left_lt ? i_new : i_left;
                    end
                end else begin
                    // drop the smallest key, pull smaller keys left
                    if (r_lt && i_right_lt) begin
                        n_slot = i_right;
                    end else if (r_lt) begin
                        n_slot = i_new;
                    end else if (i_first) begin
                        n_slot = i_new;
                    end
                end
            end
            bcache_pkg::OP_REMOVE: begin
                if (i_cmd.hit && !r_lt) begin
                    n_slot = i_right;
                end
            end
            bcache_pkg::OP_CLEAR: begin
                n_slot.valid = 1'b0;
            end
            default: begin
                n_slot = w_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_lt <= r_valid && (r_key < i_cmp_key);
                r_eq <= r_valid && (r_key == i_cmp_key);
            end
            if (i_cmd.apply) begin
                r_valid <= n_slot.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_key   <= n_slot.key;
            r_value <= n_slot.value;
        end
    end

    assign o_slot = w_cur;
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;

endmodule

// File: rtl/core/bcache_row.sv
module bcache_row (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bcache_pkg::t_cell_cmd            i_cmd,
    input  logic [bcache_pkg::KEY_W-1:0]     i_cmp_key,
    input  logic [bcache_pkg::KEY_W-1:0]     i_new_key,
    input  logic [bcache_pkg::VALUE_W-1:0]   i_new_value,
    output logic                             o_hit,
    output logic [bcache_pkg::VALUE_W-1:0]   o_read_value,
    output logic [bcache_pkg::DEPTH-1:0]     o_valid
);

    bcache_pkg::t_slot w_slot [bcache_pkg::DEPTH];
    logic [bcache_pkg::DEPTH-1:0] w_lt;
    logic [bcache_pkg::DEPTH-1:0] w_eq;
    bcache_pkg::t_slot w_new;

    assign w_new = '{valid: 1'b1, key: i_new_key, value: i_new_value};

    for (genvar g = 0; g < bcache_pkg::DEPTH; g++) begin : g_cell
        bcache_pkg::t_slot w_left;
        bcache_pkg::t_slot w_right;
        logic              w_left_lt;
        logic              w_right_lt;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_lt = 1'b1;
        end else begin : g_mid_l
            assign w_left    = w_slot[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == bcache_pkg::DEPTH - 1) begin : g_tail
            assign w_right    = '0;
            assign w_right_lt = 1'b0;
        end else begin : g_mid_r
            assign w_right    = w_slot[g+1];
            assign w_right_lt = w_lt[g+1];
        end

        bcache_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (i_cmd),
            .i_first    ((g == 0) ? 1'b1 : 1'b0),
            .i_cmp_key  (i_cmp_key),
            .i_new      (w_new),
            .i_left     (w_left),
            .i_left_lt  (w_left_lt),
            .i_right    (w_right),
            .i_right_lt (w_right_lt),
            .o_slot     (w_slot[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );

        assign o_valid[g] = w_slot[g].valid;
    end

    assign o_hit = |w_eq;

    always_comb begin
        o_read_value = '0;
        for (int i = 0; i < bcache_pkg::DEPTH; i++) begin
            o_read_value = o_read_value | (w_eq[i] ? w_slot[i].value : '0);
        end
    end

endmodule
